@@ design/pbtp_pkg.sv @@
// pbtp_pkg: shared types and constants of the 4bpp tile packer
// payload structs for both channels, controller/datapath command and status
// no dependencies
package pbtp_pkg;

    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int WORDS_OUT           = 16;
    localparam int WORD_CNT_W          = $clog2(WORDS_OUT);
    localparam int IDX_W               = 4;
    localparam int CH_IN_W             = 8;
    localparam int CH_W                = 5;
    localparam int COLOR_W             = 3 * CH_W;
    localparam int VALUE_W             = 15;

    localparam logic KIND_TILE_BYTE = 1'b0;
    localparam logic KIND_PAL_WORD  = 1'b1;

    typedef struct packed {
        logic [CH_IN_W-1:0] pixel_red;
        logic [CH_IN_W-1:0] pixel_green;
        logic [CH_IN_W-1:0] pixel_blue;
        logic               last_pixel;
    } pixel_t;

    typedef struct packed {
        logic               result_kind;
        logic [VALUE_W-1:0] result_value;
        logic               overflow;
        logic               last_result;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic pixel_ready;
        logic take_pixel;
        logic emit_word;
        logic clear_image;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic pixel_last;
        logic dump_done;
    } status_t;

endpackage

@@ design/palette_building_4bpp_tile_packer_core.sv @@
// palette_building_4bpp_tile_packer_core: top level of the 4bpp tile packer
// depends on pbtp_pkg, pbtp_ctrl, pbtp_datapath
//
//   channel  valid         stall         payload
//   pixel    pixel_valid   pixel_stall   pixel  (pbtp_pkg::pixel_t)
//   result   result_valid  result_stall  result (pbtp_pkg::result_t)
//
// one pixel a cycle while pixel_stall is low: the palette compare runs over all entries in parallel
// each pixel pair, or a lone last pixel, gives one tile byte through a single output register
// a last pixel starts a palette dump of 16 words, one word a cycle
// while result_stall is low, during which pixel_stall is high
// result_stall holds the output register and, through it, stalls intake
// reset clears palette count, pairing and overflow state; no clearing pass
module palette_building_4bpp_tile_packer_core #(
    parameter int PALETTE_ENTRIES = pbtp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  pbtp_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output pbtp_pkg::result_t result
);
    import pbtp_pkg::*;

    cmd_t    cmd;
    status_t status;

    pbtp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .status      (status),
        .cmd         (cmd)
    );

    pbtp_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign pixel_stall = ~cmd.pixel_ready;

endmodule

@@ design/pbtp_ctrl.sv @@
// pbtp_ctrl: sequencer for pixel intake and the end-of-image palette dump
// depends on pbtp_pkg
module pbtp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    input  pbtp_pkg::status_t status,
    output pbtp_pkg::cmd_t    cmd
);
    import pbtp_pkg::*;

    typedef enum logic {
        ST_PIXEL,
        ST_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        case (state_reg)
            ST_PIXEL:
            begin
                cmd.pixel_ready = status.slot_free;
                cmd.take_pixel  = status.slot_free & pixel_valid;
                if (cmd.take_pixel && status.pixel_last)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                cmd.emit_word = status.slot_free;
                if (status.slot_free && status.dump_done)
                begin
                    cmd.clear_image = 1'b1;
                    state_next      = ST_PIXEL;
                end
            end
            default:
            begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PIXEL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/pbtp_datapath.sv @@
// pbtp_datapath: palette registers with parallel compare, nibble pairing,
// palette word readout and the output register; depends on pbtp_pkg
module pbtp_datapath #(
    parameter int PALETTE_ENTRIES = pbtp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pbtp_pkg::pixel_t  pixel,
    input  pbtp_pkg::cmd_t    cmd,
    output pbtp_pkg::status_t status,
    output logic              result_valid,
    input  logic              result_stall,
    output pbtp_pkg::result_t result
);
    import pbtp_pkg::*;

    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    logic [COLOR_W-1:0]    pal_reg [PALETTE_ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      held_reg;
    logic                  phase_reg;
    logic                  ovf_reg;
    logic [WORD_CNT_W-1:0] word_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [COLOR_W-1:0] color;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               full;
    logic               add_entry;
    logic [IDX_W-1:0]   pix_idx;
    logic               ovf_next;
    logic [COLOR_W-1:0] word_value;
    result_t            byte_res;
    result_t            word_res;

    assign color = {pixel.pixel_blue[CH_IN_W-1 -: CH_W],
                    pixel.pixel_green[CH_IN_W-1 -: CH_W],
                    pixel.pixel_red[CH_IN_W-1 -: CH_W]};

    // lowest matching filled entry wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = PALETTE_ENTRIES - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < count_reg) && (pal_reg[i] == color))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign full      = (count_reg == CNT_W'(PALETTE_ENTRIES));
    assign add_entry = cmd.take_pixel & ~hit & ~full;
    assign ovf_next  = ovf_reg | (~hit & full);

    always_comb
    begin
        if (hit)
            pix_idx = hit_idx;
        else if (full)
            pix_idx = '0;
        else
            pix_idx = IDX_W'(count_reg);
    end

    always_comb
    begin
        byte_res              = '0;
        byte_res.result_kind  = KIND_TILE_BYTE;
        byte_res.overflow     = ovf_next;
        if (phase_reg)
            byte_res.result_value = VALUE_W'({pix_idx, held_reg});
        else
            byte_res.result_value = VALUE_W'(pix_idx);
    end

    // entries beyond the filled count, or beyond the store, read as zero
    always_comb
    begin
        word_value = '0;
        for (int j = 0; j < PALETTE_ENTRIES; j++)
        begin
            if ((word_reg == WORD_CNT_W'(j)) && (CNT_W'(j) < count_reg))
                word_value = pal_reg[j];
        end
    end

    always_comb
    begin
        word_res              = '0;
        word_res.result_kind  = KIND_PAL_WORD;
        word_res.result_value = VALUE_W'(word_value);
        word_res.overflow     = ovf_reg;
        word_res.last_result  = (word_reg == WORD_CNT_W'(WORDS_OUT - 1));
    end

    assign status.slot_free  = ~out_valid_reg | ~result_stall;
    assign status.pixel_last = pixel.last_pixel;
    assign status.dump_done  = (word_reg == WORD_CNT_W'(WORDS_OUT - 1));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            if (add_entry && (count_reg == CNT_W'(i)))
                pal_reg[i] <= color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            held_reg      <= '0;
            phase_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_pixel)
            begin
                ovf_reg <= ovf_next;
                if (add_entry)
                    count_reg <= count_reg + 1'b1;
                if (phase_reg || pixel.last_pixel)
                begin
                    phase_reg <= 1'b0;
                    held_reg  <= '0;
                end
                else
                begin
                    phase_reg <= 1'b1;
                    held_reg  <= pix_idx;
                end
            end
            if (cmd.clear_image)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                word_reg  <= '0;
            end
            else if (cmd.emit_word)
                word_reg <= word_reg + 1'b1;
            if (cmd.take_pixel && (phase_reg || pixel.last_pixel))
                out_valid_reg <= 1'b1;
            else if (cmd.emit_word)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel && (phase_reg || pixel.last_pixel))
            out_reg <= byte_res;
        else if (cmd.emit_word)
            out_reg <= word_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the 4bpp tile packer with palette build
// depends on pbtp_pkg and palette_building_4bpp_tile_packer_core
// predicts packed tile bytes and palette words per pixel and checks each output
`timescale 1ns / 1ps

module tb_top;

    import pbtp_pkg::*;

    localparam int PAL_ENTRIES = PALETTE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTED = 40;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    pixel_valid  = 1'b0;
    logic    pixel_stall;
    pixel_t  pixel        = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predicted image state
    logic [COLOR_W-1:0] palette [PAL_ENTRIES];
    int                 colours_used  = 0;
    logic [IDX_W-1:0]   held_nibble   = '0;
    logic               pair_held     = 1'b0;
    logic               overflow_seen = 1'b0;

    result_t packed_output_q [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          burst_left     = 8;
    logic        gaps_on        = 1'b1;
    logic        hold_request   = 1'b0;
    int          hold_left      = 0;
    int          mode_left      = 0;
    stall_mode_e stall_mode     = STALL_NONE;

    palette_building_4bpp_tile_packer_core #(
        .PALETTE_ENTRIES (PAL_ENTRIES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic logic [IDX_W-1:0] palette_index(input logic [COLOR_W-1:0] colour);
        for (int i = 0; i < colours_used; i++)
            if (palette[i] == colour)
                return IDX_W'(i);
        if (colours_used < PAL_ENTRIES)
        begin
            palette[colours_used] = colour;
            colours_used++;
            return IDX_W'(colours_used - 1);
        end
        overflow_seen = 1'b1;
        return '0;
    endfunction

    function automatic void push_result(input logic kind, input logic [VALUE_W-1:0] value,
                                        input logic last);
        result_t r;
        r.result_kind  = kind;
        r.result_value = value;
        r.overflow     = overflow_seen;
        r.last_result  = last;
        packed_output_q.push_back(r);
    endfunction

    function automatic void pack_pixel(input pixel_t px);
        logic [COLOR_W-1:0] colour;
        logic [IDX_W-1:0]   idx;
        colour = {px.pixel_blue[7:3], px.pixel_green[7:3], px.pixel_red[7:3]};
        idx    = palette_index(colour);
        if (pair_held)
        begin
            push_result(KIND_TILE_BYTE, VALUE_W'({idx, held_nibble}), 1'b0);
            pair_held   = 1'b0;
            held_nibble = '0;
        end
        else if (px.last_pixel)
            push_result(KIND_TILE_BYTE, VALUE_W'(idx), 1'b0);
        else
        begin
            held_nibble = idx;
            pair_held   = 1'b1;
        end
        if (px.last_pixel)
        begin
            for (int w = 0; w < WORDS_OUT; w++)
                push_result(KIND_PAL_WORD, (w < colours_used) ? palette[w] : '0,
                            w == WORDS_OUT - 1);
            colours_used  = 0;
            held_nibble   = '0;
            pair_held     = 1'b0;
            overflow_seen = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------ output check

    always @(posedge clk)
    begin : check_outputs
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (packed_output_q.size() == 0)
                report_mismatch("unexpected transaction", int'(result), 0);
            else
            begin
                want = packed_output_q.pop_front();
                if (result.result_kind !== want.result_kind)
                    report_mismatch("result_kind", int'(result.result_kind),
                                    int'(want.result_kind));
                if (result.result_value !== want.result_value)
                    report_mismatch("result_value", int'(result.result_value),
                                    int'(want.result_value));
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", int'(result.overflow), int'(want.overflow));
                if (result.last_result !== want.last_result)
                    report_mismatch("last_result", int'(result.last_result),
                                    int'(want.last_result));
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     result_stall <= 1'b0;
                STALL_LIGHT:    result_stall <= ($urandom_range(0, 9) < 3);
                STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
                STALL_PERIODIC: result_stall <= (cycle_count % 3 == 0);
                default:        result_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------ sender

    task automatic send_pixel(input pixel_t px);
        pixel       <= px;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall !== 1'b0)
            @(posedge clk);
        pack_pixel(px);
        items_sent++;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                pixel_valid <= 1'b0;
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic wait_for_drain();
        if (pixel_valid)
            pixel_valid <= 1'b0;
        @(posedge clk);
        while (packed_output_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(input int r, input int g, input int b,
                                          input logic last);
        pixel_t px;
        px.pixel_red   = CH_IN_W'(r);
        px.pixel_green = CH_IN_W'(g);
        px.pixel_blue  = CH_IN_W'(b);
        px.last_pixel  = last;
        return px;
    endfunction

    // ------------------------------------------------------------------- tests

    // channel extremes; low three bits must not split a colour
    task automatic test_colour_extremes();
        send_pixel(make_pixel('h00, 'h00, 'h00, 1'b0));
        send_pixel(make_pixel('h07, 'h07, 'h07, 1'b0));
        send_pixel(make_pixel('hFF, 'hFF, 'hFF, 1'b0));
        send_pixel(make_pixel('hF8, 'h07, 'hFF, 1'b1));
    endtask

    // odd pixel count, and almost every palette word unused
    task automatic test_single_pixel_image();
        send_pixel(make_pixel('hA5, 'h5A, 'h3C, 1'b1));
    endtask

    // seventeen distinct colours, then a repeat of an early entry
    task automatic test_palette_overflow();
        for (int i = 0; i < 17; i++)
            send_pixel(make_pixel(i << 3, 'hFF - (i << 3), (i * 24) & 'hFF, 1'b0));
        send_pixel(make_pixel((5 << 3) | 3, ('hFF - (5 << 3)) & 'hF9, 120 | 6, 1'b1));
    endtask

    // images drawn from small colour sets, so palettes fill, hit and overflow
    task automatic test_random_images(input int target);
        pixel_t colour_set [20];
        int     n_colours;
        int     n_pixels;
        pixel_t px;
        while (items_sent < target)
        begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            n_colours = $urandom_range(1, 20);
            for (int k = 0; k < n_colours; k++)
                colour_set[k] = pixel_t'({$urandom, 1'b0});
            n_pixels = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24);
            for (int p = 0; p < n_pixels; p++)
            begin
                if ($urandom_range(0, 9) == 0)
                    px = pixel_t'($urandom);
                else
                begin
                    px = colour_set[$urandom_range(0, n_colours - 1)];
                    px.pixel_red[2:0]   = 3'($urandom);
                    px.pixel_green[2:0] = 3'($urandom);
                    px.pixel_blue[2:0]  = 3'($urandom);
                end
                px.last_pixel = (p == n_pixels - 1);
                send_pixel(px);
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while pixels keep coming, so intake must stall
    task automatic test_output_backpressure();
        pixel_t px;
        gaps_on = 1'b0;
        hold_request <= 1'b1;
        for (int p = 0; p < 24; p++)
        begin
            px = pixel_t'({$urandom, 1'b0});
            px.pixel_red[7:6] = 2'(p % 3);
            px.pixel_green    = 8'h40;
            px.pixel_blue     = 8'h80;
            px.last_pixel     = (p == 23);
            send_pixel(px);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_colour_extremes();
        test_single_pixel_image();
        test_palette_overflow();
        wait_for_drain();
        test_random_images(220);
        test_output_backpressure();
        wait_for_drain();
        test_random_images(420);
        wait_for_drain();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/pbtp_pkg.sv
design/pbtp_ctrl.sv
design/pbtp_datapath.sv
design/palette_building_4bpp_tile_packer_core.sv
tb/tb_top.sv
